[hw/rtl/mrtb_pkg.sv]
// Shared types, constants and codes of the multi-resource token budget.
package mrtb_pkg;

	localparam int AMT_W      = 40;
	localparam int RATE_W     = 32;
	localparam int FRAC_W     = 17;
	localparam int RATE_FRAC  = 16;
	localparam int FRAC_STEPS = 16;
	localparam int NBUCKET    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int PROD_W     = 2 * RATE_W;
	localparam int WIDE_W     = RATE_W + AMT_W;

	localparam logic [AMT_W-1:0]  AMT_MAX     = {AMT_W{1'b1}};
	localparam logic [AMT_W-1:0]  CAP_RESET   = 40'd6553600;
	localparam logic [RATE_W-1:0] RATE_RESET  = 32'd65536;
	localparam logic [FRAC_W-1:0] STARV_RESET = 17'd6554;
	localparam logic [FRAC_W-1:0] FRAC_ONE    = 17'h10000;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_CONSUME = 2'd1,
		OP_RELEASE = 2'd2,
		OP_EXPAND  = 2'd3
	} op_t;

	localparam logic [1:0] RES_POWER   = 2'd0;
	localparam logic [1:0] RES_COMPUTE = 2'd1;
	localparam logic [1:0] RES_STORAGE = 2'd2;
	localparam logic [1:0] RES_NETWORK = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_POWER_CAP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMPUTE_CAP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STORAGE_CAP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NETWORK_CAP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_RATE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COMPUTE_RATE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NETWORK_RATE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STARV_LEVEL = 3'd7;

	typedef struct packed {
		op_t              op;
		logic [1:0]       resource;
		logic [AMT_W-1:0] amount;
	} in_t;

	typedef struct packed {
		logic              ok;
		logic [FRAC_W-1:0] power_fraction;
		logic [FRAC_W-1:0] compute_fraction;
		logic [FRAC_W-1:0] storage_fraction;
		logic [FRAC_W-1:0] network_fraction;
		logic [FRAC_W-1:0] viability;
		logic              starving;
	} out_t;

endpackage

[hw/rtl/mrtb_mul.sv]
// Shared 32x32 unsigned multiplier with registered product.
module mrtb_mul (
	input  logic                          clk,
	input  logic [mrtb_pkg::RATE_W-1:0]   a,
	input  logic [mrtb_pkg::RATE_W-1:0]   b,
	output logic [mrtb_pkg::PROD_W-1:0]   p
);

	logic [mrtb_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= mrtb_pkg::PROD_W'(a) * mrtb_pkg::PROD_W'(b);
	end

	assign p = p_q;

endmodule

[hw/rtl/mrtb_div.sv]
// Iterative fill-fraction divider: available over capacity in Q1.16, one bit a cycle.
module mrtb_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mrtb_pkg::AMT_W-1:0]    num,
	input  logic [mrtb_pkg::AMT_W-1:0]    den,
	output logic                          done,
	output logic [mrtb_pkg::FRAC_W-1:0]   quo
);

	localparam logic [3:0] LAST_STEP = 4'(mrtb_pkg::FRAC_STEPS - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [3:0]                    cnt_q;
	logic [mrtb_pkg::AMT_W-1:0]    r_q;
	logic [mrtb_pkg::AMT_W-1:0]    den_q;
	logic [mrtb_pkg::FRAC_W-1:0]   q_q;
	logic [mrtb_pkg::AMT_W:0]      r2;
	logic [mrtb_pkg::AMT_W:0]      diff;
	logic                          bit_set;

	always_comb begin
		r2      = {r_q, 1'b0};
		diff    = r2 - {1'b0, den_q};
		bit_set = (r2 >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= start ? (den == '0 || num >= den)
				: (busy_q && cnt_q == LAST_STEP);
			if (start) begin
				den_q <= den;
				cnt_q <= '0;
				if (den == '0) begin
					q_q    <= '0;
				end else if (num >= den) begin
					q_q    <= mrtb_pkg::FRAC_ONE;
				end else begin
					r_q    <= num;
					q_q    <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				r_q   <= bit_set ? diff[mrtb_pkg::AMT_W-1:0] : r2[mrtb_pkg::AMT_W-1:0];
				q_q   <= {q_q[mrtb_pkg::FRAC_W-2:0], bit_set};
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == LAST_STEP)
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

[hw/rtl/multi_resource_token_budget.sv]
// Top level: four token buckets with a sequencer over a shared multiplier and divider.
//
//  channel  | direction | handshake             | word
//  ---------+-----------+-----------------------+-----------------------------
//  in       | to block  | in_valid / in_stall   | in_word  (op, resource, amount)
//  out      | from block| out_valid / out_stall | out_word (ok, fractions, ...)
//  cfg      | to block  | cfg_we                | cfg_index, cfg_data
//
// Each accepted item runs four divisions, one per bucket; a division finishes early for
// a bucket with zero capacity or a full bucket. A refilling tick first runs the shared
// multiplier for the power, compute and network buckets.
// Reset loads capacities and available amounts from the register reset values.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled output holds the next result back in the final state.
module multi_resource_token_budget (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mrtb_pkg::in_t                       in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output mrtb_pkg::out_t                      out_word,
	input  logic                                cfg_we,
	input  logic [mrtb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mrtb_pkg::AMT_W-1:0]          cfg_data
);

	localparam int AW = mrtb_pkg::AMT_W;
	localparam int RW = mrtb_pkg::RATE_W;
	localparam int FW = mrtb_pkg::FRAC_W;
	localparam int PW = mrtb_pkg::PROD_W;
	localparam int WW = mrtb_pkg::WIDE_W;
	localparam int RF = mrtb_pkg::RATE_FRAC;

	typedef enum logic [2:0] {
		S_IDLE, S_OP, S_MUL_LO, S_MUL_HI, S_FILL, S_DIV_GO, S_DIV_WAIT, S_DONE
	} state_t;

	state_t                  state_q;
	mrtb_pkg::op_t           op_q;
	logic [AW-1:0]           amt_q;
	logic                    ok_q;
	logic [1:0]              bi_q;
	logic [AW-1:0]           cap_q [mrtb_pkg::NBUCKET];
	logic [AW-1:0]           av_q  [mrtb_pkg::NBUCKET];
	logic [RW-1:0]           rate_pow_q;
	logic [RW-1:0]           rate_cmp_q;
	logic [RW-1:0]           rate_net_q;
	logic [FW-1:0]           starv_q;
	logic [FW-1:0]           f_q   [mrtb_pkg::NBUCKET];
	logic [FW-1:0]           v_q;
	logic [PW-1:0]           acc_q;
	logic                    out_valid_q;
	mrtb_pkg::out_t          out_q;

	logic [AW-1:0]           cap_sel;
	logic [AW-1:0]           av_sel;
	logic [RW-1:0]           rate_sel;
	logic [RW-1:0]           mul_b;
	logic [PW-1:0]           mul_p;
	logic [WW-1:0]           wide;
	logic [AW-1:0]           inc_tick;
	logic [AW-1:0]           fill_inc;
	logic [AW:0]             fill_sum;
	logic [AW-1:0]           fill_new;
	logic [AW:0]             cap_sum;
	logic [AW:0]             av_sum;
	logic                    div_start;
	logic                    div_done;
	logic [FW-1:0]           div_quo;
	logic                    out_load;

	always_comb begin
		cap_sel = cap_q[bi_q];
		av_sel  = av_q[bi_q];
		case (bi_q)
			mrtb_pkg::RES_POWER:   rate_sel = rate_pow_q;
			mrtb_pkg::RES_COMPUTE: rate_sel = rate_cmp_q;
			mrtb_pkg::RES_NETWORK: rate_sel = rate_net_q;
			default:               rate_sel = '0;
		endcase
		mul_b = (state_q == S_MUL_LO) ? amt_q[RW-1:0] : RW'(amt_q[AW-1:RW]);
		wide  = {mul_p[AW-1:0], {RW{1'b0}}} + WW'(acc_q);
		inc_tick = (|wide[WW-1:AW+RF]) ? mrtb_pkg::AMT_MAX : wide[AW+RF-1:RF];
		fill_inc = (op_q == mrtb_pkg::OP_TICK) ? inc_tick : amt_q;
		fill_sum = {1'b0, av_sel} + {1'b0, fill_inc};
		if (fill_inc == '0)
			fill_new = av_sel;
		else if (av_sel >= cap_sel || fill_sum >= {1'b0, cap_sel})
			fill_new = cap_sel;
		else
			fill_new = fill_sum[AW-1:0];
		cap_sum = {1'b0, cap_sel} + {1'b0, amt_q};
		av_sum  = {1'b0, av_sel} + {1'b0, amt_q};
		div_start = (state_q == S_DIV_GO);
		out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	mrtb_mul u_mul (
		.clk (clk),
		.a   (rate_sel),
		.b   (mul_b),
		.p   (mul_p)
	);

	mrtb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (av_sel),
		.den    (cap_sel),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= mrtb_pkg::OP_TICK;
			ok_q        <= 1'b1;
			bi_q        <= '0;
			out_valid_q <= 1'b0;
			rate_pow_q  <= mrtb_pkg::RATE_RESET;
			rate_cmp_q  <= mrtb_pkg::RATE_RESET;
			rate_net_q  <= mrtb_pkg::RATE_RESET;
			starv_q     <= mrtb_pkg::STARV_RESET;
			v_q         <= '0;
			for (int i = 0; i < mrtb_pkg::NBUCKET; i++) begin
				cap_q[i] <= mrtb_pkg::CAP_RESET;
				av_q[i]  <= mrtb_pkg::CAP_RESET;
				f_q[i]   <= '0;
			end
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						case (cfg_index)
							mrtb_pkg::REG_POWER_CAP, mrtb_pkg::REG_COMPUTE_CAP,
							mrtb_pkg::REG_STORAGE_CAP, mrtb_pkg::REG_NETWORK_CAP: begin
								cap_q[cfg_index[1:0]] <= cfg_data;
								av_q[cfg_index[1:0]]  <= cfg_data;
							end
							mrtb_pkg::REG_POWER_RATE:   rate_pow_q <= cfg_data[RW-1:0];
							mrtb_pkg::REG_COMPUTE_RATE: rate_cmp_q <= cfg_data[RW-1:0];
							mrtb_pkg::REG_NETWORK_RATE: rate_net_q <= cfg_data[RW-1:0];
							mrtb_pkg::REG_STARV_LEVEL:  starv_q    <= cfg_data[FW-1:0];
							default: ;
						endcase
					end
					if (in_valid) begin
						op_q    <= in_word.op;
						amt_q   <= in_word.amount;
						ok_q    <= 1'b1;
						state_q <= S_OP;
						case (in_word.op)
							mrtb_pkg::OP_TICK:    bi_q <= mrtb_pkg::RES_POWER;
							mrtb_pkg::OP_RELEASE: bi_q <= mrtb_pkg::RES_STORAGE;
							default:              bi_q <= in_word.resource;
						endcase
					end
				end
				S_OP: begin
					if (op_q == mrtb_pkg::OP_TICK && amt_q != '0)
						state_q <= S_MUL_LO;
					else
						state_q <= S_DIV_GO;
					case (op_q)
						mrtb_pkg::OP_TICK: begin
							if (amt_q == '0)
								bi_q <= '0;
						end
						mrtb_pkg::OP_CONSUME: begin
							if (amt_q != '0) begin
								if (av_sel < amt_q)
									ok_q <= 1'b0;
								else
									av_q[bi_q] <= av_sel - amt_q;
							end
							bi_q <= '0;
						end
						mrtb_pkg::OP_RELEASE: begin
							av_q[bi_q] <= fill_new;
							bi_q       <= '0;
						end
						mrtb_pkg::OP_EXPAND: begin
							cap_q[bi_q] <= cap_sum[AW] ? mrtb_pkg::AMT_MAX : cap_sum[AW-1:0];
							av_q[bi_q]  <= av_sum[AW] ? mrtb_pkg::AMT_MAX : av_sum[AW-1:0];
							bi_q        <= '0;
						end
						default: ;
					endcase
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: begin
					acc_q   <= mul_p;
					state_q <= S_FILL;
				end
				S_FILL: begin
					av_q[bi_q] <= fill_new;
					case (bi_q)
						mrtb_pkg::RES_POWER: begin
							bi_q    <= mrtb_pkg::RES_COMPUTE;
							state_q <= S_MUL_LO;
						end
						mrtb_pkg::RES_COMPUTE: begin
							bi_q    <= mrtb_pkg::RES_NETWORK;
							state_q <= S_MUL_LO;
						end
						default: begin
							bi_q    <= '0;
							state_q <= S_DIV_GO;
						end
					endcase
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						f_q[bi_q] <= div_quo;
						if (bi_q == '0 || div_quo < v_q)
							v_q <= div_quo;
						if (bi_q == mrtb_pkg::RES_NETWORK) begin
							state_q <= S_DONE;
						end else begin
							bi_q    <= bi_q + 2'd1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_q.ok               <= ok_q;
						out_q.power_fraction   <= f_q[mrtb_pkg::RES_POWER];
						out_q.compute_fraction <= f_q[mrtb_pkg::RES_COMPUTE];
						out_q.storage_fraction <= f_q[mrtb_pkg::RES_STORAGE];
						out_q.network_fraction <= f_q[mrtb_pkg::RES_NETWORK];
						out_q.viability        <= v_q;
						out_q.starving         <= (v_q < starv_q);
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_avail_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		av_q[0] <= cap_q[0] && av_q[1] <= cap_q[1] &&
		av_q[2] <= cap_q[2] && av_q[3] <= cap_q[3])
		else $error("available above capacity");

	a_viability_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.viability <= out_word.power_fraction &&
		out_word.viability <= out_word.compute_fraction &&
		out_word.viability <= out_word.storage_fraction &&
		out_word.viability <= out_word.network_fraction))
		else $error("viability is not the minimum fraction");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.power_fraction <= mrtb_pkg::FRAC_ONE &&
		out_word.compute_fraction <= mrtb_pkg::FRAC_ONE &&
		out_word.storage_fraction <= mrtb_pkg::FRAC_ONE &&
		out_word.network_fraction <= mrtb_pkg::FRAC_ONE))
		else $error("fraction above one");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV_WAIT)
		else $error("divider finished outside its wait state");

endmodule

[tb/multi_resource_token_budget_test.sv]
// Self-checking testbench for the four-bucket token budget block: directed, extreme and random words.
module multi_resource_token_budget_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AMT_W      = mrtb_pkg::AMT_W;
	localparam int RATE_W     = mrtb_pkg::RATE_W;
	localparam int FRAC_W     = mrtb_pkg::FRAC_W;
	localparam int NBUCKET    = mrtb_pkg::NBUCKET;
	localparam int CFG_IDX_W  = mrtb_pkg::CFG_IDX_W;
	localparam int WIDE_W     = mrtb_pkg::WIDE_W;
	localparam int RATE_FRAC  = mrtb_pkg::RATE_FRAC;
	localparam int FRAC_STEPS = mrtb_pkg::FRAC_STEPS;
	localparam logic [AMT_W-1:0]  AMT_MAX  = mrtb_pkg::AMT_MAX;
	localparam logic [FRAC_W-1:0] FRAC_ONE = mrtb_pkg::FRAC_ONE;

	localparam logic [AMT_W-1:0] UNIT = 40'd65536;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	mrtb_pkg::in_t        in_word   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	mrtb_pkg::out_t       out_word;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [AMT_W-1:0]     cfg_data  = '0;

	// predicted bucket state and settings
	logic [AMT_W-1:0]  bucket_cap  [NBUCKET];
	logic [AMT_W-1:0]  bucket_left [NBUCKET];
	logic [RATE_W-1:0] refill_rate [NBUCKET];
	logic [FRAC_W-1:0] starve_level;

	mrtb_pkg::out_t fractions_due [$];
	int   errors        = 0;
	int   results_seen  = 0;
	int   ops_seen [4]  = '{default: 0};
	int   refusals      = 0;
	int   starving_seen = 0;
	int   setups        = 0;
	int   tx_idle_pct   = 0;
	int   rx_idle_pct   = 0;
	int   hold_len      = 0;
	logic rx_hold       = 1'b0;
	event hold_start;

	multi_resource_token_budget i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [AMT_W-1:0] refill_amount(logic [RATE_W-1:0] rate,
			logic [AMT_W-1:0] dt);
		logic [WIDE_W-1:0] prod;
		prod = {{AMT_W{1'b0}}, rate} * {{RATE_W{1'b0}}, dt};
		if ((prod >> RATE_FRAC) > AMT_MAX)
			return AMT_MAX;
		return prod[RATE_FRAC +: AMT_W];
	endfunction

	function automatic void top_up(int b, logic [AMT_W-1:0] inc);
		if (inc == '0)
			return;
		if (bucket_left[b] >= bucket_cap[b] || inc >= bucket_cap[b] - bucket_left[b])
			bucket_left[b] = bucket_cap[b];
		else
			bucket_left[b] = bucket_left[b] + inc;
	endfunction

	function automatic logic [AMT_W-1:0] grow(logic [AMT_W-1:0] a, logic [AMT_W-1:0] b);
		logic [AMT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AMT_W] ? AMT_MAX : s[AMT_W-1:0];
	endfunction

	function automatic logic [FRAC_W-1:0] fill_fraction(int b);
		logic [AMT_W+FRAC_STEPS-1:0] q;
		if (bucket_cap[b] == '0)
			return '0;
		if (bucket_left[b] >= bucket_cap[b])
			return FRAC_ONE;
		q = {bucket_left[b], {FRAC_STEPS{1'b0}}} / bucket_cap[b];
		return q[FRAC_W-1:0];
	endfunction

	function automatic mrtb_pkg::out_t budget_step(mrtb_pkg::in_t w);
		mrtb_pkg::out_t    r;
		logic [FRAC_W-1:0] f [NBUCKET];
		r = '0;
		r.ok = 1'b1;
		ops_seen[w.op]++;
		case (w.op)
			mrtb_pkg::OP_TICK: begin
				if (w.amount != '0)
					for (int b = 0; b < NBUCKET; b++)
						if (b != mrtb_pkg::RES_STORAGE)
							top_up(b, refill_amount(refill_rate[b], w.amount));
			end
			mrtb_pkg::OP_CONSUME: begin
				if (w.amount != '0) begin
					if (bucket_left[w.resource] < w.amount) begin
						r.ok = 1'b0;
						refusals++;
					end else begin
						bucket_left[w.resource] = bucket_left[w.resource] - w.amount;
					end
				end
			end
			mrtb_pkg::OP_RELEASE: top_up(mrtb_pkg::RES_STORAGE, w.amount);
			mrtb_pkg::OP_EXPAND: begin
				bucket_cap[w.resource]  = grow(bucket_cap[w.resource], w.amount);
				bucket_left[w.resource] = grow(bucket_left[w.resource], w.amount);
			end
			default: ;
		endcase
		for (int b = 0; b < NBUCKET; b++)
			f[b] = fill_fraction(b);
		r.power_fraction   = f[mrtb_pkg::RES_POWER];
		r.compute_fraction = f[mrtb_pkg::RES_COMPUTE];
		r.storage_fraction = f[mrtb_pkg::RES_STORAGE];
		r.network_fraction = f[mrtb_pkg::RES_NETWORK];
		r.viability = f[0];
		for (int b = 1; b < NBUCKET; b++)
			if (f[b] < r.viability)
				r.viability = f[b];
		r.starving = r.viability < starve_level;
		if (r.starving)
			starving_seen++;
		return r;
	endfunction

	function automatic mrtb_pkg::in_t budget_word(mrtb_pkg::op_t op, logic [1:0] res,
			logic [AMT_W-1:0] amt);
		mrtb_pkg::in_t w;
		w.op       = op;
		w.resource = res;
		w.amount   = amt;
		return w;
	endfunction

	function automatic logic [AMT_W-1:0] rand_amount();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[AMT_W-1:0];
	endfunction

	// somewhere between zero and a quarter above the given level; up to one unit for level zero
	function automatic logic [AMT_W-1:0] near(logic [AMT_W-1:0] base);
		logic [AMT_W+9:0] t;
		if (base == '0)
			return AMT_W'($urandom_range(1, 1 << 16));
		t = ({10'b0, base} * $urandom_range(320)) >> 8;
		return (t > AMT_MAX) ? AMT_MAX : t[AMT_W-1:0];
	endfunction

	function automatic logic [AMT_W-1:0] rand_register(bit is_rate);
		case ($urandom_range(9))
			0:       return '0;
			1:       return AMT_MAX;
			2, 3:    return rand_amount();
			default: return is_rate ? AMT_W'($urandom_range(1 << 20))
					: AMT_W'($urandom_range(1, 1000)) * UNIT;
		endcase
	endfunction

	function automatic mrtb_pkg::in_t random_word();
		mrtb_pkg::in_t w;
		int  pick;
		w.resource = 2'($urandom_range(3));
		pick = $urandom_range(99);
		if (pick < 30)
			w.op = mrtb_pkg::OP_TICK;
		else if (pick < 65)
			w.op = mrtb_pkg::OP_CONSUME;
		else if (pick < 85)
			w.op = mrtb_pkg::OP_RELEASE;
		else
			w.op = mrtb_pkg::OP_EXPAND;
		case ($urandom_range(15))
			0:       w.amount = '0;
			1, 2:    w.amount = rand_amount();
			default: begin
				case (w.op)
					mrtb_pkg::OP_TICK:    w.amount = AMT_W'($urandom_range(1 << 19));
					mrtb_pkg::OP_CONSUME: w.amount = near(bucket_left[w.resource]);
					mrtb_pkg::OP_RELEASE: w.amount = near(bucket_cap[mrtb_pkg::RES_STORAGE]
							- bucket_left[mrtb_pkg::RES_STORAGE]);
					mrtb_pkg::OP_EXPAND:  w.amount = near(bucket_cap[w.resource] >> 2);
					default: ;
				endcase
			end
		endcase
		return w;
	endfunction

	task automatic note_failure(string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	task automatic compare_field(string name, logic [FRAC_W-1:0] want, logic [FRAC_W-1:0] got);
		if (got !== want)
			note_failure($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	task automatic send_word(mrtb_pkg::in_t w);
		int gap;
		if ($urandom_range(99) < tx_idle_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		fractions_due.push_back(budget_step(w));
	endtask

	task automatic finish_batch();
		in_valid <= 1'b0;
		while (fractions_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AMT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			mrtb_pkg::REG_POWER_CAP, mrtb_pkg::REG_COMPUTE_CAP,
			mrtb_pkg::REG_STORAGE_CAP, mrtb_pkg::REG_NETWORK_CAP: begin
				bucket_cap[idx]  = data;
				bucket_left[idx] = data;
			end
			mrtb_pkg::REG_POWER_RATE:
				refill_rate[mrtb_pkg::RES_POWER]   = data[RATE_W-1:0];
			mrtb_pkg::REG_COMPUTE_RATE:
				refill_rate[mrtb_pkg::RES_COMPUTE] = data[RATE_W-1:0];
			mrtb_pkg::REG_NETWORK_RATE:
				refill_rate[mrtb_pkg::RES_NETWORK] = data[RATE_W-1:0];
			mrtb_pkg::REG_STARV_LEVEL:  starve_level = data[FRAC_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(logic [AMT_W-1:0] cap, logic [AMT_W-1:0] rate,
			logic [AMT_W-1:0] level);
		for (int i = 0; i < NBUCKET; i++)
			write_reg(CFG_IDX_W'(mrtb_pkg::REG_POWER_CAP + i), cap);
		write_reg(mrtb_pkg::REG_POWER_RATE, rate);
		write_reg(mrtb_pkg::REG_COMPUTE_RATE, rate);
		write_reg(mrtb_pkg::REG_NETWORK_RATE, rate);
		write_reg(mrtb_pkg::REG_STARV_LEVEL, level);
		setups++;
	endtask

	task automatic random_setup();
		for (int i = 0; i < NBUCKET; i++)
			write_reg(CFG_IDX_W'(mrtb_pkg::REG_POWER_CAP + i), rand_register(1'b0));
		write_reg(mrtb_pkg::REG_POWER_RATE, rand_register(1'b1));
		write_reg(mrtb_pkg::REG_COMPUTE_RATE, rand_register(1'b1));
		write_reg(mrtb_pkg::REG_NETWORK_RATE, rand_register(1'b1));
		write_reg(mrtb_pkg::REG_STARV_LEVEL, AMT_W'($urandom_range(FRAC_ONE)));
		setups++;
	endtask

	// reset settings: capacities 100.0, rates 1.0
	task automatic test_directed_ops();
		send_word(budget_word(mrtb_pkg::OP_TICK, mrtb_pkg::RES_NETWORK, '0));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_POWER, '0));
		send_word(budget_word(mrtb_pkg::OP_RELEASE, mrtb_pkg::RES_COMPUTE, '0));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_POWER, 30 * UNIT));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_COMPUTE, 200 * UNIT));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_NETWORK, 100 * UNIT));
		send_word(budget_word(mrtb_pkg::OP_TICK, mrtb_pkg::RES_POWER, 5 * UNIT));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_STORAGE, 50 * UNIT));
		send_word(budget_word(mrtb_pkg::OP_RELEASE, mrtb_pkg::RES_POWER, 20 * UNIT));
		send_word(budget_word(mrtb_pkg::OP_RELEASE, mrtb_pkg::RES_NETWORK, AMT_MAX));
		send_word(budget_word(mrtb_pkg::OP_TICK, mrtb_pkg::RES_STORAGE, AMT_MAX));
		send_word(budget_word(mrtb_pkg::OP_EXPAND, mrtb_pkg::RES_COMPUTE, 10 * UNIT));
		send_word(budget_word(mrtb_pkg::OP_EXPAND, mrtb_pkg::RES_STORAGE, '0));
		send_word(budget_word(mrtb_pkg::OP_EXPAND, mrtb_pkg::RES_POWER, AMT_MAX));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_POWER, AMT_MAX));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_POWER, 40'd1));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_NETWORK, 40'd1));
		send_word(budget_word(mrtb_pkg::OP_EXPAND, mrtb_pkg::RES_NETWORK, AMT_MAX));
		send_word(budget_word(mrtb_pkg::OP_TICK, mrtb_pkg::RES_COMPUTE, 40'd1));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_STORAGE, 40'hAA_AAAA_AAAA));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_COMPUTE, 40'h55_5555_5555));
		finish_batch();
	endtask

	task automatic test_register_extremes();
		write_all('0, '0, '0);
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_STORAGE, 40'd1));
		send_word(budget_word(mrtb_pkg::OP_TICK, mrtb_pkg::RES_POWER, AMT_MAX));
		send_word(budget_word(mrtb_pkg::OP_RELEASE, mrtb_pkg::RES_STORAGE, 5 * UNIT));
		send_word(budget_word(mrtb_pkg::OP_EXPAND, mrtb_pkg::RES_POWER, 40'd1));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_POWER, '0));
		finish_batch();
		write_all(AMT_MAX, AMT_MAX, AMT_W'(FRAC_ONE));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_NETWORK, AMT_MAX >> 1));
		send_word(budget_word(mrtb_pkg::OP_TICK, mrtb_pkg::RES_NETWORK, 40'd1));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_STORAGE, AMT_MAX));
		send_word(budget_word(mrtb_pkg::OP_RELEASE, mrtb_pkg::RES_STORAGE, 40'd1));
		send_word(budget_word(mrtb_pkg::OP_EXPAND, mrtb_pkg::RES_COMPUTE, 40'd1));
		send_word(budget_word(mrtb_pkg::OP_CONSUME, mrtb_pkg::RES_POWER, 40'd3));
		send_word(budget_word(mrtb_pkg::OP_TICK, mrtb_pkg::RES_POWER, AMT_MAX));
		finish_batch();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_len = 600;
		-> hold_start;
		for (int n = 0; n < 8; n++)
			send_word(random_word());
		finish_batch();
		for (int n = 0; n < 6; n++) begin
			send_word(random_word());
			if (n == 2)
				finish_batch();
		end
		finish_batch();
	endtask

	task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int n = 0; n < count; n++) begin
			if (n != 0 && n % 110 == 0)
				finish_batch();
			if (n % 110 == 0)
				random_setup();
			send_word(random_word());
		end
		finish_batch();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
	end

	// long receiver hold-off, counted here
	initial forever begin
		@(hold_start);
		rx_hold <= 1'b1;
		repeat (hold_len) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin : watch_results
		mrtb_pkg::out_t due;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (fractions_due.size() == 0) begin
				note_failure("result word arrived with nothing expected");
			end else begin
				due = fractions_due.pop_front();
				compare_field("ok", FRAC_W'(due.ok), FRAC_W'(out_word.ok));
				compare_field("power_fraction", due.power_fraction, out_word.power_fraction);
				compare_field("compute_fraction", due.compute_fraction, out_word.compute_fraction);
				compare_field("storage_fraction", due.storage_fraction, out_word.storage_fraction);
				compare_field("network_fraction", due.network_fraction, out_word.network_fraction);
				compare_field("viability", due.viability, out_word.viability);
				compare_field("starving", FRAC_W'(due.starving), FRAC_W'(out_word.starving));
			end
		end
	end

	initial begin
		for (int b = 0; b < NBUCKET; b++) begin
			bucket_cap[b]  = mrtb_pkg::CAP_RESET;
			bucket_left[b] = mrtb_pkg::CAP_RESET;
			refill_rate[b] = mrtb_pkg::RATE_RESET;
		end
		refill_rate[mrtb_pkg::RES_STORAGE] = '0;
		starve_level = mrtb_pkg::STARV_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_register_extremes();
		test_backpressure();
		test_random_traffic(550, 30, 51);
		test_random_traffic(550, 51, 30);
		test_random_traffic(550, 0, 0);
		repeat (100) @(posedge clk);
		if (fractions_due.size() != 0)
			note_failure("expected results never arrived");
		$display("Checked %0d results: %0d ticks, %0d consumes (%0d refused), %0d releases, %0d expands.",
			results_seen, ops_seen[mrtb_pkg::OP_TICK], ops_seen[mrtb_pkg::OP_CONSUME], refusals,
			ops_seen[mrtb_pkg::OP_RELEASE], ops_seen[mrtb_pkg::OP_EXPAND]);
		$display("%0d register setups incl. all-zero and all-max, %0d starving reports, %0d mismatches.",
			setups, starving_seen, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
